// ===== rtl/gom_pkg.sv =====
// Shared types, constants and the modular correction function for the group order arithmetic core.
`timescale 1ns / 1ps
package gom_pkg;

    localparam int OP_W  = 256;
    localparam int DIG_W = 32;

    localparam logic [255:0] MOD_N =
        256'hB6400000_02A3A6F1_D603AB4F_F58EC744_49F2934B_18EA8BEE_E56EE19C_D69ECF25;
    localparam logic [255:0] MOD_NEG_N =
        256'h49BFFFFF_FD5C590E_29FC54B0_0A7138BB_B60D6CB4_E7157411_1A911E63_296130DB;
    localparam logic [255:0] MOD_N_PRIME =
        256'hE3582ED4_CAA6FF31_205F4C4B_48175059_F590740D_939A510D_1D026623_51974B53;
    localparam logic [255:0] MOD_R2 =
        256'h8894F5D1_63695D0E_BFEE4BAE_7D78A1F9_E4A08110_BB6DAEAB_7598CD79_CD750C35;
    localparam logic [255:0] MOD_N_MINUS_TWO =
        256'hB6400000_02A3A6F1_D603AB4F_F58EC744_49F2934B_18EA8BEE_E56EE19C_D69ECF23;
    localparam logic [255:0] WORD_ONE = 256'd1;

    typedef enum logic [3:0] {
        CMD_LOAD_A    = 4'd0,
        CMD_LOAD_B    = 4'd1,
        CMD_ADD       = 4'd2,
        CMD_SUB       = 4'd3,
        CMD_MUL       = 4'd4,
        CMD_SQR       = 4'd5,
        CMD_TO_MONT   = 4'd6,
        CMD_FROM_MONT = 4'd7,
        CMD_POW       = 4'd8,
        CMD_INV       = 4'd9
    } t_cmd;

    typedef enum logic [3:0] {
        T_IDLE, T_ADDFIX, T_SUBFIX, T_MM, T_PW_SQ, T_PW_TBL,
        T_PW_SCAN, T_PW_SQR, T_PW_MUL, T_OUT
    } t_top_state;

    typedef enum logic [3:0] {
        M_IDLE, M_P, M_WP, M_Q, M_WQ, M_QN, M_WQN, M_ADDLO, M_ADDHI, M_FIX
    } t_mont_state;

    typedef struct packed {
        logic start;
        logic low_only;
    } t_mul_ctl;

    // On a carry out of 2^256 add -n, otherwise subtract n when at or above n.
    function automatic logic [255:0] f_correct(input logic [255:0] z, input logic c);
        logic [255:0] r;
        if (c) begin
            r = z + MOD_NEG_N;
        end else if (z >= MOD_N) begin
            r = z - MOD_N;
        end else begin
            r = z;
        end
        return r;
    endfunction

endpackage

// ===== rtl/gom_if.sv =====
// Valid/ready channel interfaces for command beats and result limb beats.
`timescale 1ns / 1ps
interface gom_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [1:0]  limb_index;
    logic [63:0] limb_value;
    modport source (output valid, cmd, limb_index, limb_value, input ready);
    modport sink (input valid, cmd, limb_index, limb_value, output ready);
endinterface

interface gom_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_index;
    logic [63:0] result_limb;
    logic        last;
    modport source (output valid, result_index, result_limb, last, input ready);
    modport sink (input valid, result_index, result_limb, last, output ready);
endinterface

// ===== rtl/gom_mul.sv =====
// Shared 32x32 multiplier with column-wise accumulation of a 256x256 product.
`timescale 1ns / 1ps
module gom_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gom_pkg::t_mul_ctl i_ctl,
    input  logic [255:0]      i_x,
    input  logic [255:0]      i_y,
    output logic              o_done,
    output logic [511:0]      o_prod
);
    import gom_pkg::*;

    logic        r_run;
    logic [3:0]  r_col;
    logic [2:0]  r_row;
    logic        r_low;
    logic        r_pv;
    logic        r_done;
    logic        r_plast;
    logic        r_pfin;
    logic [3:0]  r_pcol;
    logic [63:0] r_pp;
    logic [71:0] r_acc;
    logic [511:0] r_prod;

    logic [3:0]  col_last;
    logic [2:0]  row_hi;
    logic [3:0]  col_n;
    logic [2:0]  row_lo_n;
    logic [2:0]  col_j;
    logic [31:0] x_d;
    logic [31:0] y_d;
    logic [71:0] acc_sum;
    logic        row_end;

    always_comb begin
        col_last = r_low ? 4'd7 : 4'd14;
        row_hi   = (r_col > 4'd7) ? 3'd7 : r_col[2:0];
        col_n    = r_col + 4'd1;
        row_lo_n = (col_n > 4'd7) ? 3'(col_n - 4'd7) : 3'd0;
        col_j    = 3'(r_col - {1'b0, r_row});
        x_d      = i_x[DIG_W*r_row +: DIG_W];
        y_d      = i_y[DIG_W*col_j +: DIG_W];
        acc_sum  = r_acc + {8'd0, r_pp};
        row_end  = (r_row == row_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_col  <= 4'd0;
            r_row  <= 3'd0;
            r_low  <= 1'b0;
        end else begin
            r_done <= r_pv && r_pfin;
            r_pv   <= r_run;
            if (i_ctl.start) begin
                r_run <= 1'b1;
                r_col <= 4'd0;
                r_row <= 3'd0;
                r_low <= i_ctl.low_only;
            end else if (r_run) begin
                if (row_end) begin
                    if (r_col == col_last) begin
                        r_run <= 1'b0;
                    end else begin
                        r_col <= col_n;
                        r_row <= row_lo_n;
                    end
                end else begin
                    r_row <= r_row + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run) begin
            r_pp    <= x_d * y_d;
            r_plast <= row_end;
            r_pfin  <= row_end && (r_col == col_last);
            r_pcol  <= r_col;
        end
        if (i_ctl.start) begin
            r_acc <= 72'd0;
        end else if (r_pv) begin
            if (r_plast) begin
                r_prod[DIG_W*r_pcol +: DIG_W] <= acc_sum[31:0];
                r_acc <= 72'(acc_sum >> DIG_W);
                if (r_pfin && !r_low) begin
                    r_prod[511:480] <= acc_sum[63:32];
                end
            end else begin
                r_acc <= acc_sum;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ===== rtl/gom_mont.sv =====
// Montgomery product sequencer: product, quotient, reduction add and final correction.
`timescale 1ns / 1ps
module gom_mont (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_x,
    input  logic [255:0] i_y,
    output logic         o_done,
    output logic [255:0] o_z
);
    import gom_pkg::*;

    t_mont_state  r_state, n_state;
    logic         r_done;
    logic [511:0] r_p;
    logic [255:0] r_q;
    logic [255:0] r_z;
    logic         r_c;

    t_mul_ctl     mul_ctl;
    logic [255:0] mul_x, mul_y;
    logic         mul_done;
    logic [511:0] mul_prod;
    logic [256:0] lo_sum, hi_sum;

    gom_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE:  if (i_start) n_state = M_P;
            M_P:     n_state = M_WP;
            M_WP:    if (mul_done) n_state = M_Q;
            M_Q:     n_state = M_WQ;
            M_WQ:    if (mul_done) n_state = M_QN;
            M_QN:    n_state = M_WQN;
            M_WQN:   if (mul_done) n_state = M_ADDLO;
            M_ADDLO: n_state = M_ADDHI;
            M_ADDHI: n_state = M_FIX;
            M_FIX:   n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_comb begin
        mul_ctl.start    = (r_state == M_P) || (r_state == M_Q) || (r_state == M_QN);
        mul_ctl.low_only = (r_state == M_Q);
        case (r_state)
            M_Q, M_WQ: begin
                mul_x = r_p[255:0];
                mul_y = MOD_N_PRIME;
            end
            M_QN, M_WQN: begin
                mul_x = r_q;
                mul_y = MOD_N;
            end
            default: begin
                mul_x = i_x;
                mul_y = i_y;
            end
        endcase
    end

    assign lo_sum = {1'b0, r_p[255:0]} + {1'b0, mul_prod[255:0]};
    assign hi_sum = {1'b0, r_p[511:256]} + {1'b0, mul_prod[511:256]} + 257'(r_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_WP:    if (mul_done) r_p <= mul_prod;
            M_WQ:    if (mul_done) r_q <= mul_prod[255:0];
            M_ADDLO: r_c <= lo_sum[256];
            M_ADDHI: begin
                r_z <= hi_sum[255:0];
                r_c <= hi_sum[256];
            end
            M_FIX:   r_z <= f_correct(r_z, r_c);
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_z    = r_z;

endmodule

// ===== rtl/group_order_montgomery_arith_core.sv =====
// Top level: command decode, operand store, power sequencer and result limb output.
`timescale 1ns / 1ps
// Arithmetic core modulo the fixed 256-bit group order n.
// Command channel (i_item): one beat per command. Loads write one 64-bit limb of
// operand A or B and produce no result; unused codes are dropped without result.
// Result channel (o_res): every arithmetic command returns four limb beats,
// least significant first, with last set on the fourth.
// i_item.ready is high only while the core is idle, so one command is in work at
// a time. Add and sub pass through a correction state before the result beats. A
// Montgomery product is three 256x256 products built from one shared 32x32
// multiplier; power and inverse take up to (2^(WINDOW_BITS-1) + 256 +
// 256/WINDOW_BITS) Montgomery products with the default 4-bit window.
// When the receiver stalls, hold the current limb beat until taken; no new command
// is taken until all four beats are gone. Synchronous reset clears the sequencers
// and both operands to zero.
module group_order_montgomery_arith_core #(
    parameter int WINDOW_BITS = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gom_in_if.sink   i_item,
    gom_out_if.source o_res
);
    import gom_pkg::*;

    localparam int TS     = 1 << (WINDOW_BITS - 1);
    localparam int TIDX_W = (WINDOW_BITS > 1) ? WINDOW_BITS - 1 : 1;

    t_top_state   r_state, n_state;
    logic [255:0] r_a, r_b, r_e, r_z, r_sq, r_acc, r_mx, r_my;
    logic [255:0] r_tab [TS];
    logic         r_c;
    logic         r_mstart;
    logic [1:0]   r_oidx;
    logic [8:0]   r_i;
    logic [TIDX_W-1:0] r_t;
    logic [TIDX_W-1:0] r_widx;
    logic [2:0]   r_nsq;
    logic         r_domul;

    logic         in_acc;
    t_cmd         cmd;
    logic         m_done;
    logic [255:0] m_z;
    logic         l_go;
    logic [255:0] l_x, l_y;
    logic [256:0] add_sum, sub_dif;

    logic [WINDOW_BITS-1:0] wwin;
    logic [WINDOW_BITS-1:0] w_val;
    logic [2:0]   w_maxk;
    logic [2:0]   w_nsq;
    logic [TIDX_W-1:0] w_idx;
    logic         w_bit;

    gom_mont u_mont (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_x     (r_mx),
        .i_y     (r_my),
        .o_done  (m_done),
        .o_z     (m_z)
    );

    assign in_acc  = i_item.valid && i_item.ready;
    assign cmd     = t_cmd'(i_item.cmd);
    assign add_sum = {1'b0, r_a} + {1'b0, r_b};
    assign sub_dif = {1'b0, r_a} - {1'b0, r_b};

    // Window scan: take up to WINDOW_BITS exponent bits from the current position,
    // end the window on its lowest set bit.
    always_comb begin
        for (int k = 0; k < WINDOW_BITS; k++) begin
            wwin[WINDOW_BITS-1-k] = (r_i[7:0] >= 8'(k)) ? r_e[r_i[7:0] - 8'(k)] : 1'b0;
        end
        w_maxk = 3'd0;
        for (int k = 1; k < WINDOW_BITS; k++) begin
            if (wwin[WINDOW_BITS-1-k]) w_maxk = 3'(k);
        end
        w_bit = wwin[WINDOW_BITS-1];
        w_val = wwin >> (3'(WINDOW_BITS - 1) - w_maxk);
        w_idx = TIDX_W'(w_val >> 1);
        w_nsq = w_bit ? w_maxk + 3'd1 : 3'd1;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (in_acc) begin
                    case (cmd)
                        CMD_ADD: n_state = T_ADDFIX;
                        CMD_SUB: n_state = T_SUBFIX;
                        CMD_MUL, CMD_SQR, CMD_TO_MONT, CMD_FROM_MONT: n_state = T_MM;
                        CMD_POW, CMD_INV: n_state = T_PW_SQ;
                        default: n_state = T_IDLE;
                    endcase
                end
            end
            T_ADDFIX, T_SUBFIX: n_state = T_OUT;
            T_MM:     if (m_done) n_state = T_OUT;
            T_PW_SQ:  if (m_done) n_state = (TS > 1) ? T_PW_TBL : T_PW_SCAN;
            T_PW_TBL: if (m_done && r_t == TIDX_W'(TS - 1)) n_state = T_PW_SCAN;
            T_PW_SCAN: n_state = r_i[8] ? T_OUT : T_PW_SQR;
            T_PW_SQR: begin
                if (m_done && r_nsq == 3'd0) n_state = r_domul ? T_PW_MUL : T_PW_SCAN;
            end
            T_PW_MUL: if (m_done) n_state = T_PW_SCAN;
            T_OUT:    if (o_res.ready && r_oidx == 2'd3) n_state = T_IDLE;
            default:  n_state = T_IDLE;
        endcase
    end

    // Outputs and Montgomery launches
    always_comb begin
        i_item.ready       = (r_state == T_IDLE);
        o_res.valid        = (r_state == T_OUT);
        o_res.result_index = r_oidx;
        o_res.result_limb  = r_z[64*r_oidx +: 64];
        o_res.last         = (r_oidx == 2'd3);
        l_go = 1'b0;
        l_x  = r_acc;
        l_y  = r_acc;
        case (r_state)
            T_IDLE: begin
                if (in_acc) begin
                    l_x = r_a;
                    case (cmd)
                        CMD_MUL: begin
                            l_go = 1'b1;
                            l_y  = r_b;
                        end
                        CMD_SQR, CMD_POW, CMD_INV: begin
                            l_go = 1'b1;
                            l_y  = r_a;
                        end
                        CMD_TO_MONT: begin
                            l_go = 1'b1;
                            l_y  = MOD_R2;
                        end
                        CMD_FROM_MONT: begin
                            l_go = 1'b1;
                            l_y  = WORD_ONE;
                        end
                        default: l_go = 1'b0;
                    endcase
                end
            end
            T_PW_SQ: begin
                l_go = m_done && (TS > 1);
                l_x  = r_tab[0];
                l_y  = m_z;
            end
            T_PW_TBL: begin
                l_go = m_done && (r_t != TIDX_W'(TS - 1));
                l_x  = m_z;
                l_y  = r_sq;
            end
            T_PW_SCAN: l_go = !r_i[8];
            T_PW_SQR: begin
                l_go = m_done && (r_nsq != 3'd0 || r_domul);
                l_x  = m_z;
                l_y  = (r_nsq != 3'd0) ? m_z : r_tab[r_widx];
            end
            default: l_go = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_mstart <= 1'b0;
            r_oidx   <= 2'd0;
            r_a      <= '0;
            r_b      <= '0;
        end else begin
            r_state  <= n_state;
            r_mstart <= l_go;
            if (r_state == T_OUT && o_res.ready) r_oidx <= r_oidx + 2'd1;
            if (in_acc && cmd == CMD_LOAD_A) r_a[64*i_item.limb_index +: 64] <= i_item.limb_value;
            if (in_acc && cmd == CMD_LOAD_B) r_b[64*i_item.limb_index +: 64] <= i_item.limb_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_go) begin
            r_mx <= l_x;
            r_my <= l_y;
        end
        case (r_state)
            T_IDLE: begin
                if (in_acc) begin
                    case (cmd)
                        CMD_ADD: {r_c, r_z} <= add_sum;
                        CMD_SUB: {r_c, r_z} <= sub_dif;
                        CMD_POW: begin
                            r_e      <= r_b;
                            r_tab[0] <= r_a;
                        end
                        CMD_INV: begin
                            r_e      <= MOD_N_MINUS_TWO;
                            r_tab[0] <= r_a;
                        end
                        default: ;
                    endcase
                end
            end
            T_ADDFIX: r_z <= f_correct(r_z, r_c);
            T_SUBFIX: if (r_c) r_z <= r_z + MOD_N;
            T_MM:     if (m_done) r_z <= m_z;
            T_PW_SQ: begin
                if (m_done) begin
                    r_sq  <= m_z;
                    r_t   <= TIDX_W'(1);
                    r_acc <= MOD_NEG_N;
                    r_i   <= 9'd255;
                end
            end
            T_PW_TBL: begin
                if (m_done) begin
                    r_tab[r_t] <= m_z;
                    r_t        <= r_t + TIDX_W'(1);
                end
            end
            T_PW_SCAN: begin
                if (r_i[8]) begin
                    r_z <= r_acc;
                end else begin
                    r_nsq   <= w_nsq - 3'd1;
                    r_domul <= w_bit;
                    r_widx  <= w_idx;
                    r_i     <= r_i - 9'(w_nsq);
                end
            end
            T_PW_SQR: begin
                if (m_done) begin
                    if (r_nsq != 3'd0) begin
                        r_nsq <= r_nsq - 3'd1;
                    end else if (!r_domul) begin
                        r_acc <= m_z;
                    end
                end
            end
            T_PW_MUL: if (m_done) r_acc <= m_z;
            default: ;
        endcase
    end

endmodule
